[rtl/core/wsh_pkg.sv]
package wsh_pkg;

    // Source count
    localparam int MAX_SOURCES_DEF = 4;
    localparam int SRC_SLOTS       = 4;

    // Field widths
    localparam int COORD_W  = 16;
    localparam int TIME_W   = 32;
    localparam int HEIGHT_W = 24;
    localparam int CFG_W    = 64;
    localparam int INDEX_W  = 3;
    localparam int MASK_W   = 4;

    // Square root: one result bit per stage
    localparam int SQRT_STEPS = 25;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int DIST_W     = SQRT_STEPS + 1;
    localparam int DIFF_W     = TIME_W + 2;
    localparam int PHASE_W    = COORD_W + DIFF_W;

    // Phase reduction: one conditional subtract of 2*pi << k per stage
    localparam int MOD_STEPS = 21;
    localparam int MOD_W     = PHASE_W + 1;
    localparam int ANG_W     = 31;
    localparam int FOLD_W    = 29;

    localparam logic [ANG_W-1:0]  PHASE_TWO_PI  = 31'd1686629713;
    localparam logic [ANG_W-1:0]  PHASE_PI      = 31'd843314857;
    localparam logic [ANG_W-1:0]  PHASE_HALF_PI = 31'd421657428;
    localparam logic [MOD_W-1:0]  MOD_BIAS      = MOD_W'(PHASE_TWO_PI) << (MOD_STEPS - 2);
    localparam logic [FOLD_W-1:0] Q28_ONE       = 29'h1000_0000;

    // Exact reciprocals for 30-bit dividends: ceil(2^(30+l) / c), l = ceil(log2 c)
    localparam int RECIP_W = 31;
    localparam int SH_72   = 37;
    localparam int SH_42   = 36;
    localparam int SH_20   = 35;
    localparam int SH_6    = 33;
    localparam logic [RECIP_W-1:0] RECIP_72 = 31'(((64'd1 << SH_72) + 64'd71) / 64'd72);
    localparam logic [RECIP_W-1:0] RECIP_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
    localparam logic [RECIP_W-1:0] RECIP_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
    localparam logic [RECIP_W-1:0] RECIP_6  = 31'(((64'd1 << SH_6) + 64'd5) / 64'd6);

    // Signed contribution of one source, and the sum over sources
    localparam int TERM_W = 19;
    localparam int SUM_W  = 21;
    localparam int TOT_W  = HEIGHT_W + 1;

    // Lane pipeline stages: 3 set-up, square root, 3 phase, reduction, 12 sine/scale
    localparam int LANE_LAT = 3 + SQRT_STEPS + 3 + MOD_STEPS + 12;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] amp;
        logic [15:0] freq;
    } src_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_SOURCE_0      = 3'd0,
        REG_SOURCE_1      = 3'd1,
        REG_SOURCE_2      = 3'd2,
        REG_SOURCE_3      = 3'd3,
        REG_ENABLE_MASK   = 3'd4,
        REG_HEIGHT_OFFSET = 3'd5
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] SRC_RESET [SRC_SLOTS] = '{
        64'h0000_0000_1000_0C00,
        64'h0A00_0A00_1000_0C00,
        64'h0,
        64'h0
    };
    localparam logic [MASK_W-1:0]   MASK_RESET   = 4'h3;
    localparam logic [HEIGHT_W-1:0] OFFSET_RESET = 24'h0;

endpackage

[rtl/core/wsh_lane.sv]
module wsh_lane (
    input  logic                                  clk,
    input  logic                                  adv,
    input  logic [wsh_pkg::COORD_W-1:0]           px,
    input  logic [wsh_pkg::COORD_W-1:0]           py,
    input  logic [wsh_pkg::TIME_W-1:0]            tnow,
    input  wsh_pkg::src_t                         src,
    output logic signed [wsh_pkg::TERM_W-1:0]     term
);

    localparam int RAD_W   = wsh_pkg::RAD_W;
    localparam int SQ_N    = wsh_pkg::SQRT_STEPS;
    localparam int MOD_W   = wsh_pkg::MOD_W;
    localparam int MOD_N   = wsh_pkg::MOD_STEPS;
    localparam int TIME_W  = wsh_pkg::TIME_W;
    localparam int FOLD_W  = wsh_pkg::FOLD_W;

    // Set-up stages
    logic signed [16:0]     dx_reg, dy_reg;
    logic [TIME_W-1:0]      t1_reg, t2_reg;
    logic signed [33:0]     sqx_w, sqy_w;
    logic [32:0]            sqx_reg, sqy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg  <= {px[15], px} - {src.x[15], src.x};
            dy_reg  <= {py[15], py} - {src.y[15], src.y};
            t1_reg  <= tnow;
            sqx_reg <= sqx_w[32:0];
            sqy_reg <= sqy_w[32:0];
            t2_reg  <= t1_reg;
        end
    end

    assign sqx_w = dx_reg * dx_reg;
    assign sqy_w = dy_reg * dy_reg;

    // Square root of (dx^2 + dy^2) << 16, one bit per stage
    logic [RAD_W-1:0]  sq_v_reg [0:SQ_N];
    logic [RAD_W-1:0]  sq_r_reg [0:SQ_N];
    logic [TIME_W-1:0] sq_t_reg [0:SQ_N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_v_reg[0] <= {({1'b0, sqx_reg} + {1'b0, sqy_reg}), 16'h0};
            sq_r_reg[0] <= '0;
            sq_t_reg[0] <= t2_reg;
        end
    end

    for (genvar j = 1; j <= SQ_N; j++)
    begin : g_sqrt
        localparam logic [RAD_W-1:0] SQ_BIT = RAD_W'(1) << (2 * (SQ_N - j));
        logic [RAD_W-1:0] trial;
        logic [RAD_W-1:0] v_next;
        logic [RAD_W-1:0] r_next;

        always_comb
        begin
            trial = sq_r_reg[j-1] + SQ_BIT;
            if (sq_v_reg[j-1] >= trial)
            begin
                v_next = sq_v_reg[j-1] - trial;
                r_next = (sq_r_reg[j-1] >> 1) + SQ_BIT;
            end
            else
            begin
                v_next = sq_v_reg[j-1];
                r_next = sq_r_reg[j-1] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_v_reg[j] <= v_next;
                sq_r_reg[j] <= r_next;
                sq_t_reg[j] <= sq_t_reg[j-1];
            end
        end
    end

    // Phase: freq * (t - d), biased positive
    logic signed [wsh_pkg::DIFF_W-1:0]  diff_reg;
    logic signed [wsh_pkg::PHASE_W-1:0] ph_w, ph_reg;
    logic signed [15:0]                 fq;
    logic [wsh_pkg::DIST_W-1:0]         dist_q;
    logic [MOD_W-1:0]                   md_reg [0:MOD_N];

    assign fq     = src.freq;
    assign dist_q = sq_r_reg[SQ_N][wsh_pkg::DIST_W-1:0];
    assign ph_w   = fq * diff_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg  <= {{2{sq_t_reg[SQ_N][TIME_W-1]}}, sq_t_reg[SQ_N]}
                         - {8'h0, dist_q};
            ph_reg    <= ph_w;
            md_reg[0] <= {ph_reg[wsh_pkg::PHASE_W-1], ph_reg} + wsh_pkg::MOD_BIAS;
        end
    end

    // Reduce modulo 2*pi, one multiple per stage
    for (genvar j = 1; j <= MOD_N; j++)
    begin : g_mod
        localparam logic [MOD_W-1:0] SUB = MOD_W'(wsh_pkg::PHASE_TWO_PI) << (MOD_N - j);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (md_reg[j-1] >= SUB)
                begin
                    md_reg[j] <= md_reg[j-1] - SUB;
                end
                else
                begin
                    md_reg[j] <= md_reg[j-1];
                end
            end
        end
    end

    // Fold to [0, pi/2] with a sign
    logic [wsh_pkg::ANG_W-1:0] r0, r1, r2;
    logic                      fold_neg;

    always_comb
    begin
        r0       = md_reg[MOD_N][wsh_pkg::ANG_W-1:0];
        fold_neg = (r0 >= wsh_pkg::PHASE_PI);
        r1       = fold_neg ? (r0 - wsh_pkg::PHASE_PI) : r0;
        if (r1 > wsh_pkg::PHASE_HALF_PI)
        begin
            r2 = (r1 <= wsh_pkg::PHASE_PI) ? (wsh_pkg::PHASE_PI - r1) : '0;
        end
        else
        begin
            r2 = r1;
        end
    end

    // Taylor series in Horner form, at most one multiply per stage
    logic [FOLD_W-1:0] r_pipe_reg [53:61];
    logic              neg_pipe_reg [53:63];
    logic [29:0]       x2_pipe_reg [55:59];
    logic [57:0]       x2p_reg, s_reg;
    logic [60:0]       p72_reg, p42_reg, p20_reg, p6_reg;
    logic [58:0]       m1_reg, m2_reg, m3_reg;
    logic [45:0]       pr_reg;
    logic [FOLD_W-1:0] t1, t2, t3, t4;
    logic [29:0]       x2;
    logic [57:0]       x2p_w, s_w;
    logic [60:0]       p72_w, p42_w, p20_w, p6_w;
    logic [58:0]       m1_w, m2_w, m3_w;
    logic [45:0]       pr_w;
    logic [15:0]       amag;
    logic              aneg;
    logic [46:0]       rnd_sum;
    logic [17:0]       rnd;
    logic signed [wsh_pkg::TERM_W-1:0] term_reg;

    assign x2    = x2p_reg[57:28];
    assign t1    = wsh_pkg::Q28_ONE - {5'h0, p72_reg[60:wsh_pkg::SH_72]};
    assign t2    = wsh_pkg::Q28_ONE - {4'h0, p42_reg[60:wsh_pkg::SH_42]};
    assign t3    = wsh_pkg::Q28_ONE - {3'h0, p20_reg[60:wsh_pkg::SH_20]};
    assign t4    = wsh_pkg::Q28_ONE - {1'h0, p6_reg[60:wsh_pkg::SH_6]};
    assign x2p_w = r_pipe_reg[53] * r_pipe_reg[53];
    assign p72_w = x2 * wsh_pkg::RECIP_72;
    assign m1_w  = x2_pipe_reg[55] * t1;
    assign p42_w = m1_reg[57:28] * wsh_pkg::RECIP_42;
    assign m2_w  = x2_pipe_reg[57] * t2;
    assign p20_w = m2_reg[57:28] * wsh_pkg::RECIP_20;
    assign m3_w  = x2_pipe_reg[59] * t3;
    assign p6_w  = m3_reg[57:28] * wsh_pkg::RECIP_6;
    assign s_w   = r_pipe_reg[61] * t4;
    assign aneg  = src.amp[15];
    assign amag  = aneg ? (~src.amp + 16'd1) : src.amp;
    assign pr_w  = amag * s_reg[57:28];
    assign rnd_sum = {1'b0, pr_reg} + 47'(1 << 27);
    assign rnd   = rnd_sum[45:28];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_pipe_reg[53]   <= r2[FOLD_W-1:0];
            neg_pipe_reg[53] <= fold_neg;
            x2p_reg          <= x2p_w;
            x2_pipe_reg[55]  <= x2;
            p72_reg          <= p72_w;
            m1_reg           <= m1_w;
            p42_reg          <= p42_w;
            m2_reg           <= m2_w;
            p20_reg          <= p20_w;
            m3_reg           <= m3_w;
            p6_reg           <= p6_w;
            s_reg            <= s_w;
            pr_reg           <= pr_w;
            term_reg         <= (neg_pipe_reg[63] ^ aneg) ? -$signed({1'b0, rnd})
                                                          : $signed({1'b0, rnd});
            for (int k = 54; k <= 61; k++)
            begin
                r_pipe_reg[k] <= r_pipe_reg[k-1];
            end
            for (int k = 54; k <= 63; k++)
            begin
                neg_pipe_reg[k] <= neg_pipe_reg[k-1];
            end
            for (int k = 56; k <= 59; k++)
            begin
                x2_pipe_reg[k] <= x2_pipe_reg[k-1];
            end
        end
    end

    assign term = term_reg;

endmodule

[rtl/core/wave_superposition_height.sv]
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | point_x, point_y, time_now
// out     | output    | out_valid/out_stall| height_z
// cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// One item per cycle sustained unless the output stalls. Items pass the input
// register, the lanes, the sum register and the output register; the depth comes
// from the bit-per-stage square root and the stage-per-multiple 2*pi reduction.
// rst_n clears the configuration to its defaults and empties the pipeline.
// A stalled output parks one more result in a skid stage; only then does
// in_stall rise and the pipeline hold.
module wave_superposition_height #(
    parameter int MAX_SOURCES = wsh_pkg::MAX_SOURCES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [wsh_pkg::COORD_W-1:0]    point_x,
    input  logic signed [wsh_pkg::COORD_W-1:0]    point_y,
    input  logic signed [wsh_pkg::TIME_W-1:0]     time_now,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [wsh_pkg::HEIGHT_W-1:0]   height_z,
    input  logic                                  cfg_write,
    input  logic [wsh_pkg::INDEX_W-1:0]           cfg_index,
    input  logic [wsh_pkg::CFG_W-1:0]             cfg_data
);

    localparam int LAST     = wsh_pkg::LANE_LAT + 1;
    localparam int HEIGHT_W = wsh_pkg::HEIGHT_W;
    localparam int SUM_W    = wsh_pkg::SUM_W;
    localparam int TOT_W    = wsh_pkg::TOT_W;

    // Configuration registers
    logic [wsh_pkg::CFG_W-1:0]    src_word_reg [MAX_SOURCES];
    logic [wsh_pkg::MASK_W-1:0]   mask_reg;
    logic [HEIGHT_W-1:0]          offset_reg;

    for (genvar i = 0; i < MAX_SOURCES; i++)
    begin : g_src_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                src_word_reg[i] <= wsh_pkg::SRC_RESET[i];
            end
            else if (cfg_write
                     && cfg_index == 3'(wsh_pkg::REG_SOURCE_0) + 3'(i))
            begin
                src_word_reg[i] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= wsh_pkg::MASK_RESET;
            offset_reg <= wsh_pkg::OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wsh_pkg::REG_ENABLE_MASK:   mask_reg   <= cfg_data[wsh_pkg::MASK_W-1:0];
                wsh_pkg::REG_HEIGHT_OFFSET: offset_reg <= cfg_data[HEIGHT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Whole pipeline advances unless the skid stage holds an item
    logic adv;
    logic skid_full_reg, skid_full_next;

    assign adv      = !skid_full_reg;
    assign in_stall = skid_full_reg;

    // Valid bits travel beside the data: 0 input, 1..LANE_LAT lanes, LAST sum
    logic vld_reg [0:LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Input stage
    logic [wsh_pkg::COORD_W-1:0] px_reg, py_reg;
    logic [wsh_pkg::TIME_W-1:0]  t_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            t_reg  <= time_now;
        end
    end

    // One lane per source
    logic signed [wsh_pkg::TERM_W-1:0] terms [MAX_SOURCES];

    for (genvar i = 0; i < MAX_SOURCES; i++)
    begin : g_lane
        wsh_lane u_lane (
            .clk  (clk),
            .adv  (adv),
            .px   (px_reg),
            .py   (py_reg),
            .tnow (t_reg),
            .src  (wsh_pkg::src_t'(src_word_reg[i])),
            .term (terms[i])
        );
    end

    // Sum enabled sources
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] sum_reg;

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < MAX_SOURCES; i++)
        begin
            if (mask_reg[i])
            begin
                acc = acc + SUM_W'(terms[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= acc;
        end
    end

    // Add the offset and saturate
    logic signed [TOT_W-1:0]    tot;
    logic signed [HEIGHT_W-1:0] sat;

    assign tot = TOT_W'(sum_reg) + TOT_W'($signed(offset_reg));

    always_comb
    begin
        if (tot[TOT_W-1] != tot[TOT_W-2])
        begin
            sat = tot[TOT_W-1] ? {1'b1, {(HEIGHT_W-1){1'b0}}}
                               : {1'b0, {(HEIGHT_W-1){1'b1}}};
        end
        else
        begin
            sat = tot[HEIGHT_W-1:0];
        end
    end

    // Output register plus one skid entry
    logic                       out_valid_reg, out_valid_next;
    logic [HEIGHT_W-1:0]        hz_reg, hz_next;
    logic [HEIGHT_W-1:0]        skid_hz_reg, skid_hz_next;
    logic                       take, arrive;

    assign take   = out_valid_reg && !out_stall;
    assign arrive = adv && vld_reg[LAST];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        hz_next        = hz_reg;
        skid_full_next = skid_full_reg;
        skid_hz_next   = skid_hz_reg;
        if (take || !out_valid_reg)
        begin
            if (skid_full_reg)
            begin
                // drain the skid entry; the pipeline is held this cycle
                out_valid_next = 1'b1;
                hz_next        = skid_hz_reg;
                skid_full_next = 1'b0;
            end
            else
            begin
                out_valid_next = arrive;
                if (arrive)
                begin
                    hz_next = sat;
                end
            end
        end
        else if (arrive)
        begin
            // output stalled: park the new item
            skid_full_next = 1'b1;
            skid_hz_next   = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hz_reg      <= hz_next;
        skid_hz_reg <= skid_hz_next;
    end

    assign out_valid = out_valid_reg;
    assign height_z  = hz_reg;

endmodule

[rtl/core/wsh_checker.sv]
module wsh_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic signed [wsh_pkg::COORD_W-1:0]    point_x,
    input logic signed [wsh_pkg::COORD_W-1:0]    point_y,
    input logic signed [wsh_pkg::TIME_W-1:0]     time_now,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [wsh_pkg::HEIGHT_W-1:0]   height_z,
    input logic                                  cfg_write,
    input logic [wsh_pkg::INDEX_W-1:0]           cfg_index,
    input logic [wsh_pkg::CFG_W-1:0]             cfg_data
);

    // Held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(height_z))
        else $error("stalled result changed");

    // Input backpressure only follows a stalled, full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid entry held with empty output");

    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("skid entry not drained");

endmodule

bind wave_superposition_height wsh_checker u_wsh_checker (.*);

[bench/wave_superposition_height_tb.sv]
`timescale 1ns / 100ps

module wave_superposition_height_tb;

    localparam int LAT_CYCLES  = wsh_pkg::LANE_LAT + 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 43;
    localparam int HOLD_ITEMS  = 100;

    // Scoreboard: expected heights in arrival order, and the mismatch tally.
    class height_scoreboard;
        logic signed [wsh_pkg::HEIGHT_W-1:0] pending[$];
        int errors;

        function void note_point(logic signed [wsh_pkg::HEIGHT_W-1:0] z);
            pending = {pending, z};
        endfunction

        function void check_height(logic signed [wsh_pkg::HEIGHT_W-1:0] z);
            logic signed [wsh_pkg::HEIGHT_W-1:0] want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected height %0d", z);
                return;
            end
            want = pending.pop_front();
            if (want !== z)
            begin
                errors++;
                if (errors <= 10)
                    $display("height mismatch: expected %0d got %0d", want, z);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [wsh_pkg::COORD_W-1:0] point_x = '0;
    logic signed [wsh_pkg::COORD_W-1:0] point_y = '0;
    logic signed [wsh_pkg::TIME_W-1:0] time_now = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [wsh_pkg::HEIGHT_W-1:0] height_z;
    logic cfg_write = 1'b0;
    logic [wsh_pkg::INDEX_W-1:0] cfg_index = '0;
    logic [wsh_pkg::CFG_W-1:0] cfg_data = '0;

    height_scoreboard board;
    logic [wsh_pkg::CFG_W-1:0] src_shadow [wsh_pkg::SRC_SLOTS];
    logic [wsh_pkg::MASK_W-1:0] mask_shadow;
    logic [wsh_pkg::HEIGHT_W-1:0] offset_shadow;
    int cycle_count = 0;
    bit long_hold = 1'b0;

    always #10 clk = ~clk;

    wave_superposition_height dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .time_now(time_now),
        .out_valid(out_valid), .out_stall(out_stall), .height_z(height_z),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Sine magnitude of an angle in [0, 2*pi), Q.28; the sign comes out separately.
    function automatic longint unsigned sine_q28(longint unsigned r, output bit neg);
        longint unsigned x2, t;
        neg = 1'b0;
        if (r >= wsh_pkg::PHASE_PI)
        begin
            neg = 1'b1;
            r -= wsh_pkg::PHASE_PI;
        end
        if (r > wsh_pkg::PHASE_HALF_PI)
            r = (r <= wsh_pkg::PHASE_PI) ? wsh_pkg::PHASE_PI - r : 0;
        x2 = (r * r) >> 28;
        t = wsh_pkg::Q28_ONE - x2 / 72;
        t = wsh_pkg::Q28_ONE - ((x2 * t) >> 28) / 42;
        t = wsh_pkg::Q28_ONE - ((x2 * t) >> 28) / 20;
        t = wsh_pkg::Q28_ONE - ((x2 * t) >> 28) / 6;
        return (r * t) >> 28;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Sum the enabled source waves at one point, add the offset, saturate.
    function automatic logic signed [wsh_pkg::HEIGHT_W-1:0] surface_height(
        logic signed [wsh_pkg::COORD_W-1:0] px, logic signed [wsh_pkg::COORD_W-1:0] py,
        logic signed [wsh_pkg::TIME_W-1:0] tn);
        longint sum, dx, dy, diff, phase, amp, freq;
        longint unsigned dist_q, smag, amag, prod;
        wsh_pkg::src_t s;
        bit sneg, aneg;
        sum = 0;
        for (int i = 0; i < wsh_pkg::SRC_SLOTS; i++)
        begin
            if (!mask_shadow[i])
                continue;
            s = wsh_pkg::src_t'(src_shadow[i]);
            amp = longint'($signed(s.amp));
            freq = longint'($signed(s.freq));
            dx = longint'(px) - longint'($signed(s.x));
            dy = longint'(py) - longint'($signed(s.y));
            dist_q = floor_sqrt(longint'(dx * dx + dy * dy) << 16);
            diff = longint'(tn) - longint'(dist_q);
            phase = (freq * diff) % 64'sd1686629713;
            if (phase < 0)
                phase += 64'sd1686629713;
            smag = sine_q28(phase, sneg);
            aneg = amp < 0;
            amag = aneg ? -amp : amp;
            prod = (amag * smag + (64'd1 << 27)) >> 28;
            if (aneg != sneg)
                sum -= longint'(prod);
            else
                sum += longint'(prod);
        end
        sum += longint'($signed(offset_shadow));
        if (sum > 8388607)
            sum = 8388607;
        if (sum < -8388608)
            sum = -8388608;
        return sum[wsh_pkg::HEIGHT_W-1:0];
    endfunction

    // Write one register and mirror it; high data bits drop as the block drops them.
    task automatic write_reg(wsh_pkg::cfg_reg_t idx, logic [wsh_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            wsh_pkg::REG_ENABLE_MASK:   mask_shadow = val[wsh_pkg::MASK_W-1:0];
            wsh_pkg::REG_HEIGHT_OFFSET: offset_shadow = val[wsh_pkg::HEIGHT_W-1:0];
            default:                    src_shadow[idx] = val;
        endcase
    endtask

    // Writes to indexes past the last register must be ignored.
    task automatic write_stray(logic [wsh_pkg::INDEX_W-1:0] idx);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= {$urandom, $urandom};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item and hold it until accepted; the expectation is noted on acceptance.
    task automatic send_point(logic signed [wsh_pkg::COORD_W-1:0] px,
                              logic signed [wsh_pkg::COORD_W-1:0] py,
                              logic signed [wsh_pkg::TIME_W-1:0] tn, bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x <= px;
        point_y <= py;
        time_now <= tn;
        do
            @(posedge clk);
        while (in_stall);
        board.note_point(surface_height(px, py, tn));
    endtask

    task automatic park_sender();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for the pipeline to drain before touching configuration.
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [wsh_pkg::CFG_W-1:0] rand_source(bit near);
        wsh_pkg::src_t s;
        if (near)
        begin
            s.x = 16'($signed($urandom_range(0, 8191)) - 4096);
            s.y = 16'($signed($urandom_range(0, 8191)) - 4096);
        end
        else
        begin
            s.x = 16'($urandom);
            s.y = 16'($urandom);
        end
        s.amp = 16'($urandom);
        s.freq = 16'($urandom);
        return s;
    endfunction

    task automatic send_random(int n, bit allow_gap);
        logic signed [wsh_pkg::COORD_W-1:0] px, py;
        logic signed [wsh_pkg::TIME_W-1:0] tn;
        for (int k = 0; k < n; k++)
        begin
            px = 16'($urandom);
            py = 16'($urandom);
            tn = 32'($urandom);
            if ($urandom_range(0, 3) == 0)
            begin
                // keep some points near the origin with small times
                px = 16'($signed($urandom_range(0, 8191)) - 4096);
                py = 16'($signed($urandom_range(0, 8191)) - 4096);
                tn = 32'($signed($urandom_range(0, 4000000)) - 2000000);
            end
            send_point(px, py, tn, allow_gap);
        end
        park_sender();
    endtask

    // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                g = gap_len();
                if (g != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (g) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Check every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_height(height_z);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("wave_superposition_height_tb: errors");
            $finish;
        end
    end

    initial
    begin
        board = new();
        for (int i = 0; i < wsh_pkg::SRC_SLOTS; i++)
            src_shadow[i] = wsh_pkg::SRC_RESET[i];
        mask_shadow = wsh_pkg::MASK_RESET;
        offset_shadow = wsh_pkg::OFFSET_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset: corners, zero, and extreme times.
        send_point(16'sh0, 16'sh0, 32'sh0, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 32'sh7fffffff, 1'b0);
        send_point(-16'sh8000, -16'sh8000, -32'sh80000000, 1'b0);
        send_point(16'sh7fff, -16'sh8000, 32'sh0001_0000, 1'b0);
        send_point(16'sh0a00, 16'sh0a00, 32'sh0003_243f, 1'b0);
        park_sender();
        drain();

        // No source enabled: height equals the offset, both offset extremes.
        write_reg(wsh_pkg::REG_ENABLE_MASK, 64'hffff_fff0);
        write_reg(wsh_pkg::REG_HEIGHT_OFFSET, 64'h7fffff);
        send_point(16'sh1234, -16'sh0100, 32'sh5555_0000, 1'b0);
        park_sender();
        drain();
        write_reg(wsh_pkg::REG_HEIGHT_OFFSET, 64'hffff_ffff_ff80_0000);
        send_point(16'sh0, 16'sh0, 32'sh0, 1'b0);
        park_sender();
        drain();

        // Saturation: four big amplitudes at one spot, offset near either rail.
        for (int i = 0; i < wsh_pkg::SRC_SLOTS; i++)
            write_reg(wsh_pkg::cfg_reg_t'(i), {16'h0, 16'h0, 16'h7fff, 16'h1000});
        write_reg(wsh_pkg::REG_ENABLE_MASK, 64'hf);
        write_reg(wsh_pkg::REG_HEIGHT_OFFSET, 64'h7ff000);
        send_point(16'sh0, 16'sh0, 32'sh0001_9220, 1'b0);
        send_point(16'sh0, 16'sh0, -32'sh0001_9220, 1'b0);
        park_sender();
        drain();
        write_reg(wsh_pkg::REG_HEIGHT_OFFSET, 64'h800fff);
        send_point(16'sh0, 16'sh0, 32'sh0001_9220, 1'b0);
        send_point(16'sh0, 16'sh0, -32'sh0001_9220, 1'b0);
        park_sender();
        drain();

        // Negative amplitude and frequency, extreme source words, stray indexes.
        write_reg(wsh_pkg::REG_SOURCE_0, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
        write_reg(wsh_pkg::REG_SOURCE_1, {16'h7fff, 16'h7fff, 16'hf000, 16'hf400});
        write_reg(wsh_pkg::REG_SOURCE_2, 64'hffff_ffff_ffff_ffff);
        write_reg(wsh_pkg::REG_SOURCE_3, 64'h0);
        write_reg(wsh_pkg::REG_HEIGHT_OFFSET, 64'h0);
        write_stray(3'd6);
        write_stray(3'd7);
        send_point(16'sh7fff, 16'sh7fff, 32'sh7fffffff, 1'b0);
        send_point(-16'sh8000, -16'sh8000, -32'sh80000000, 1'b0);
        send_point(16'sh0, 16'sh7fff, -32'sh1, 1'b0);
        send_point(16'shffff, 16'sh0001, 32'sh1, 1'b0);
        park_sender();
        drain();

        // Random phases: new source set each phase; one phase streams back to back
        // into a long receiver hold-off so the pipeline fills and stalls its input.
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int i = 0; i < wsh_pkg::SRC_SLOTS; i++)
                write_reg(wsh_pkg::cfg_reg_t'(i), rand_source(ph % 2 == 0));
            write_reg(wsh_pkg::REG_ENABLE_MASK, {$urandom, $urandom});
            write_reg(wsh_pkg::REG_HEIGHT_OFFSET, {$urandom, $urandom});
            if (ph == 3)
            begin
                long_hold = 1'b1;
                send_random(HOLD_ITEMS, 1'b0);
            end
            else
                send_random(PHASE_ITEMS, 1'b1);
            drain();
        end

        repeat (LAT_CYCLES + 20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("wave_superposition_height_tb: clean");
        else
            $display("wave_superposition_height_tb: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/wsh_pkg.sv
rtl/core/wsh_lane.sv
rtl/core/wave_superposition_height.sv
rtl/core/wsh_checker.sv
bench/wave_superposition_height_tb.sv
